// File: rtl/njh_pkg.sv
// shared types and constants for the navigation jump history
// no dependencies
package njh_pkg;

    localparam int DEPTH_DEFAULT = 128;

    localparam int FILE_W   = 8;
    localparam int LINE_W   = 24;
    localparam int COL_W    = 16;
    localparam int ENTRY_W  = FILE_W + LINE_W + COL_W;
    localparam int COUNT_W  = 8;
    localparam int CURSOR_W = 7;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_BACK    = 2'd1,
        OP_FORWARD = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

endpackage

// File: rtl/navigation_jump_history_top.sv
// navigation jump history: bounded back/forward ring of positions
// depends on njh_pkg
//
//  channel   signals                                           handshake
//  item in   operation, file_id, line, col                     start && !busy
//  result    ok, out_file, out_line, out_col,                  done, one cycle
//            entry_count, cursor_index
//
// one item per cycle; busy stays low after reset
// the result of an item accepted at one edge shows with done in the next cycle
// pointers update at the accept edge, the entry ram is read or written there too
// reset clears count, cursor and oldest slot; the ram needs no clearing
// the receiver cannot stall, results are never held back
module navigation_jump_history_top #(
    parameter int DEPTH = njh_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    operation,
    input  logic [njh_pkg::FILE_W-1:0]    file_id,
    input  logic [njh_pkg::LINE_W-1:0]    line,
    input  logic [njh_pkg::COL_W-1:0]     col,
    output logic                          done,
    output logic                          ok,
    output logic [njh_pkg::FILE_W-1:0]    out_file,
    output logic [njh_pkg::LINE_W-1:0]    out_line,
    output logic [njh_pkg::COL_W-1:0]     out_col,
    output logic [njh_pkg::COUNT_W-1:0]   entry_count,
    output logic [njh_pkg::CURSOR_W-1:0]  cursor_index
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EW    = njh_pkg::ENTRY_W;

    localparam logic [IDX_W:0]   DEPTH_S = (IDX_W + 1)'(DEPTH);
    localparam logic [CNT_W:0]   DEPTH_C = (CNT_W + 1)'(DEPTH);

    logic [EW-1:0]      mem [DEPTH];

    logic [IDX_W-1:0]   oldest_reg, oldest_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   cursor_reg, cursor_next;
    logic               done_reg;
    logic               ok_reg, ok_next;
    logic               hit_reg, hit_next;
    logic [EW-1:0]      rd_reg;

    logic               accept;
    logic               wr_en;
    logic [IDX_W-1:0]   slot;
    logic [CNT_W:0]     cnt_x;
    logic [CNT_W:0]     cur_x;
    logic [CNT_W:0]     cnt_trim;
    logic [IDX_W-1:0]   logical;
    logic [IDX_W:0]     slot_sum;
    njh_pkg::op_t       op;

    assign accept = start && !busy;
    assign busy   = 1'b0;
    assign op     = njh_pkg::op_t'(operation);
    assign cnt_x  = {1'b0, count_reg};
    assign cur_x  = (CNT_W + 1)'(cursor_reg);

    // ring slot of a logical position, sum stays below twice the depth
    always_comb
    begin
        slot_sum = {1'b0, oldest_reg} + {1'b0, logical};
        if (slot_sum >= DEPTH_S)
            slot = IDX_W'(slot_sum - DEPTH_S);
        else
            slot = slot_sum[IDX_W-1:0];
    end

    always_comb
    begin
        oldest_next = oldest_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        ok_next     = 1'b1;
        hit_next    = 1'b0;
        wr_en       = 1'b0;
        logical     = cursor_reg;
        cnt_trim    = cnt_x;
        case (op)
            njh_pkg::OP_PUSH:
            begin
                wr_en = accept;
                // drop forward entries past the cursor
                if (count_reg != '0 && (cur_x + 1'b1) < cnt_x)
                    cnt_trim = cur_x + 1'b1;
                if (cnt_trim >= DEPTH_C)
                begin
                    logical     = '0;
                    oldest_next = (oldest_reg == IDX_W'(DEPTH - 1)) ? '0 : oldest_reg + 1'b1;
                    count_next  = CNT_W'(DEPTH);
                    cursor_next = IDX_W'(DEPTH - 1);
                end
                else
                begin
                    logical     = IDX_W'(cnt_trim);
                    count_next  = CNT_W'(cnt_trim + 1'b1);
                    cursor_next = IDX_W'(cnt_trim);
                end
            end
            njh_pkg::OP_BACK:
            begin
                if (count_reg != '0 && cursor_reg != '0)
                begin
                    cursor_next = cursor_reg - 1'b1;
                    logical     = cursor_next;
                    hit_next    = 1'b1;
                end
                else
                    ok_next = 1'b0;
            end
            njh_pkg::OP_FORWARD:
            begin
                if (count_reg != '0 && (cur_x + 1'b1) < cnt_x)
                begin
                    cursor_next = cursor_reg + 1'b1;
                    logical     = cursor_next;
                    hit_next    = 1'b1;
                end
                else
                    ok_next = 1'b0;
            end
            njh_pkg::OP_CLEAR:
            begin
                oldest_next = '0;
                count_next  = '0;
                cursor_next = '0;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            count_reg  <= '0;
            cursor_reg <= '0;
            done_reg   <= 1'b0;
            ok_reg     <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                oldest_reg <= oldest_next;
                count_reg  <= count_next;
                cursor_reg <= cursor_next;
                ok_reg     <= ok_next;
                hit_reg    <= hit_next;
            end
        end
    end

    // entry ram, one write or one registered read per item
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[slot] <= {file_id, line, col};
        if (accept && hit_next)
            rd_reg <= mem[slot];
    end

    logic [CNT_W+njh_pkg::COUNT_W-1:0]   cnt_wide;
    logic [IDX_W+njh_pkg::CURSOR_W-1:0]  cur_wide;

    assign cnt_wide = {{njh_pkg::COUNT_W{1'b0}}, count_reg};
    assign cur_wide = {{njh_pkg::CURSOR_W{1'b0}}, cursor_reg};

    assign done         = done_reg;
    assign ok           = ok_reg;
    assign out_file     = hit_reg ? rd_reg[EW-1 -: njh_pkg::FILE_W] : '0;
    assign out_line     = hit_reg ? rd_reg[njh_pkg::COL_W +: njh_pkg::LINE_W] : '0;
    assign out_col      = hit_reg ? rd_reg[njh_pkg::COL_W-1:0] : '0;
    assign entry_count  = cnt_wide[njh_pkg::COUNT_W-1:0];
    assign cursor_index = cur_wide[njh_pkg::CURSOR_W-1:0];

endmodule

// File: rtl/njh_checker.sv
// port level checks for the navigation jump history
// depends on njh_pkg, bound to navigation_jump_history_top
module njh_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [1:0]                    operation,
    input  logic                          done,
    input  logic                          ok,
    input  logic [njh_pkg::FILE_W-1:0]    out_file,
    input  logic [njh_pkg::LINE_W-1:0]    out_line,
    input  logic [njh_pkg::COL_W-1:0]     out_col,
    input  logic [njh_pkg::COUNT_W-1:0]   entry_count,
    input  logic [njh_pkg::CURSOR_W-1:0]  cursor_index
);

    // every accepted item gives its result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("no result after accepted item");

    // no result without an item
    a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without item");

    // failed navigation returns no position
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (out_file == '0 && out_line == '0 && out_col == '0))
        else $error("failed navigation carries a position");

    // clear leaves an empty history
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == njh_pkg::OP_CLEAR)
        |=> (ok && entry_count == '0 && cursor_index == '0))
        else $error("clear did not empty history");

    // push reports success and no position
    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == njh_pkg::OP_PUSH)
        |=> (ok && out_file == '0 && out_line == '0 && out_col == '0))
        else $error("push result wrong");

endmodule

bind navigation_jump_history_top njh_checker u_njh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .done         (done),
    .ok           (ok),
    .out_file     (out_file),
    .out_line     (out_line),
    .out_col      (out_col),
    .entry_count  (entry_count),
    .cursor_index (cursor_index)
);

// File: verif/navigation_jump_history_checker.sv
// checker for the navigation jump history: predicts each result from the accepted items
// and compares it with what the block returns; depends on njh_pkg
`timescale 1ns / 1ps

module navigation_jump_history_checker #(
    parameter int DEPTH = njh_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [1:0]                    operation,
    input  logic [njh_pkg::FILE_W-1:0]    file_id,
    input  logic [njh_pkg::LINE_W-1:0]    line,
    input  logic [njh_pkg::COL_W-1:0]     col,
    input  logic                          done,
    input  logic                          ok,
    input  logic [njh_pkg::FILE_W-1:0]    out_file,
    input  logic [njh_pkg::LINE_W-1:0]    out_line,
    input  logic [njh_pkg::COL_W-1:0]     out_col,
    input  logic [njh_pkg::COUNT_W-1:0]   entry_count,
    input  logic [njh_pkg::CURSOR_W-1:0]  cursor_index,
    output int                            fail_count,
    output int                            pending
);
    import njh_pkg::*;

    typedef struct packed {
        logic                ok;
        logic [FILE_W-1:0]   file;
        logic [LINE_W-1:0]   line;
        logic [COL_W-1:0]    col;
        logic [COUNT_W-1:0]  count;
        logic [CURSOR_W-1:0] cursor;
    } nav_result_t;

    nav_result_t       expected_nav[$];

    logic [FILE_W-1:0] hist_file [DEPTH];
    logic [LINE_W-1:0] hist_line [DEPTH];
    logic [COL_W-1:0]  hist_col  [DEPTH];
    int                oldest_slot;
    int                held;
    int                cur;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic step_history(input op_t op, input logic [FILE_W-1:0] f,
                                input logic [LINE_W-1:0] l, input logic [COL_W-1:0] c,
                                output nav_result_t r);
        int slot;
        r    = '0;
        r.ok = 1'b1;
        case (op)
            OP_PUSH:
            begin
                // forward entries past the cursor are dropped
                if (held > 0 && cur + 1 < held)
                    held = cur + 1;
                if (held >= DEPTH)
                begin
                    slot        = oldest_slot;
                    oldest_slot = (oldest_slot + 1) % DEPTH;
                    held        = DEPTH;
                end
                else
                begin
                    slot = (oldest_slot + held) % DEPTH;
                    held++;
                end
                hist_file[slot] = f;
                hist_line[slot] = l;
                hist_col[slot]  = c;
                cur             = held - 1;
            end
            OP_BACK, OP_FORWARD:
            begin
                if (op == OP_BACK ? (held > 0 && cur > 0) : (held > 0 && cur + 1 < held))
                begin
                    cur    = (op == OP_BACK) ? cur - 1 : cur + 1;
                    slot   = (oldest_slot + cur) % DEPTH;
                    r.file = hist_file[slot];
                    r.line = hist_line[slot];
                    r.col  = hist_col[slot];
                end
                else
                begin
                    r.ok = 1'b0;
                end
            end
            default:
            begin
                held        = 0;
                cur         = 0;
                oldest_slot = 0;
            end
        endcase
        r.count  = held[COUNT_W-1:0];
        r.cursor = cur[CURSOR_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        nav_result_t want;
        nav_result_t got;
        if (!rst_n)
        begin
            expected_nav.delete();
            oldest_slot = 0;
            held        = 0;
            cur         = 0;
            pending     = 0;
        end
        else
        begin
            // results belong to earlier items, so compare before adding this edge's item
            if (done)
            begin
                got = {ok, out_file, out_line, out_col, entry_count, cursor_index};
                if (expected_nav.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result at %0t: ok=%0d file=%0d line=%0d %s%0d",
                                 $realtime, got.ok, got.file, got.line, "col=", got.col,
                                 " count=%0d cursor=%0d", got.count, got.cursor);
                    fail_count++;
                end
                else
                begin
                    want = expected_nav.pop_front();
                    if (got.ok !== want.ok || got.file !== want.file || got.line !== want.line
                        || got.col !== want.col || got.count !== want.count
                        || got.cursor !== want.cursor)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("mismatch at %0t: expected ok=%0d file=%0d line=%0d",
                                     $realtime, want.ok, want.file, want.line,
                                     " col=%0d count=%0d cursor=%0d",
                                     want.col, want.count, want.cursor);
                            $display("    got ok=%0d file=%0d line=%0d col=%0d",
                                     got.ok, got.file, got.line, got.col,
                                     " count=%0d cursor=%0d", got.count, got.cursor);
                        end
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                step_history(op_t'(operation), file_id, line, col, want);
                expected_nav = {expected_nav, want};
            end
            pending = expected_nav.size();
        end
    end

endmodule

// File: verif/testbench.sv
// testbench top for the navigation jump history: clock, reset, item stimulus and verdict
// depends on njh_pkg, navigation_jump_history_top and navigation_jump_history_checker
`timescale 1ns / 1ps

module testbench;
    import njh_pkg::*;

    localparam int CYCLE_LIMIT  = 60000;
    localparam int RANDOM_ITEMS = 550;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  start        = 1'b0;
    logic [1:0]            operation    = OP_PUSH;
    logic [FILE_W-1:0]     file_id      = '0;
    logic [LINE_W-1:0]     line         = '0;
    logic [COL_W-1:0]      col          = '0;
    logic                  busy;
    logic                  done;
    logic                  ok;
    logic [FILE_W-1:0]     out_file;
    logic [LINE_W-1:0]     out_line;
    logic [COL_W-1:0]      out_col;
    logic [COUNT_W-1:0]    entry_count;
    logic [CURSOR_W-1:0]   cursor_index;
    int                    fail_count;
    int                    pending;
    int                    cycles = 0;

    always #4 clk = ~clk;

    navigation_jump_history_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .file_id      (file_id),
        .line         (line),
        .col          (col),
        .done         (done),
        .ok           (ok),
        .out_file     (out_file),
        .out_line     (out_line),
        .out_col      (out_col),
        .entry_count  (entry_count),
        .cursor_index (cursor_index)
    );

    navigation_jump_history_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .file_id      (file_id),
        .line         (line),
        .col          (col),
        .done         (done),
        .ok           (ok),
        .out_file     (out_file),
        .out_line     (out_line),
        .out_col      (out_col),
        .entry_count  (entry_count),
        .cursor_index (cursor_index),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // holds the item until the block takes it
    task automatic send_item(input op_t op, input logic [FILE_W-1:0] f,
                             input logic [LINE_W-1:0] l, input logic [COL_W-1:0] c);
        start     <= 1'b1;
        operation <= op;
        file_id   <= f;
        line      <= l;
        col       <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic maybe_idle(input bit calm);
        if (!calm && $urandom_range(0, 99) < 27)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3))
                @(posedge clk);
        end
    endtask

    // mostly random, with the field extremes now and then
    function automatic logic [31:0] pick_value(input int width);
        logic [31:0] mask;
        mask = (32'd1 << width) - 32'd1;
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return mask;
            default: return $urandom() & mask;
        endcase
    endfunction

    // mode 0 fills the ring, 1 browses, 2 walks back toward the oldest, 3 mixes in clears
    function automatic op_t pick_op(input int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0:       return r < 90 ? OP_PUSH : (r < 95 ? OP_BACK : OP_FORWARD);
            1:       return r < 20 ? OP_PUSH : (r < 60 ? OP_BACK : OP_FORWARD);
            2:       return r < 10 ? OP_PUSH : (r < 85 ? OP_BACK : OP_FORWARD);
            default: return r < 45 ? OP_PUSH
                          : (r < 70 ? OP_BACK : (r < 95 ? OP_FORWARD : OP_CLEAR));
        endcase
    endfunction

    task automatic send_random(input int mode);
        send_item(pick_op(mode), FILE_W'(pick_value(FILE_W)), LINE_W'(pick_value(LINE_W)),
                  COL_W'(pick_value(COL_W)));
    endtask

    initial
    begin
        int sent;
        int seg;
        int mode;
        int len;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // navigation on an empty history fails
        send_item(OP_BACK, 8'hff, 24'hffffff, 16'hffff);
        maybe_idle(1'b0);
        send_item(OP_FORWARD, 8'h00, 24'h000000, 16'h0000);
        maybe_idle(1'b0);
        send_item(OP_PUSH, 8'h00, 24'h000000, 16'h0000);
        send_item(OP_PUSH, 8'hff, 24'hffffff, 16'hffff);
        maybe_idle(1'b0);
        send_item(OP_PUSH, 8'ha5, 24'h5a5a5a, 16'ha5a5);
        send_item(OP_PUSH, 8'h5a, 24'ha5a5a5, 16'h5a5a);
        // forward at the newest entry fails
        send_item(OP_FORWARD, 8'h12, 24'h345678, 16'h9abc);
        send_item(OP_BACK, 8'h00, 24'h000000, 16'h0000);
        maybe_idle(1'b0);
        send_item(OP_BACK, 8'h00, 24'h000000, 16'h0000);
        send_item(OP_BACK, 8'h00, 24'h000000, 16'h0000);
        // back at the oldest entry fails
        send_item(OP_BACK, 8'h00, 24'h000000, 16'h0000);
        send_item(OP_FORWARD, 8'h00, 24'h000000, 16'h0000);
        maybe_idle(1'b0);
        // push from the middle drops the forward entries
        send_item(OP_PUSH, 8'h3c, 24'h123456, 16'h0f0f);
        send_item(OP_FORWARD, 8'h00, 24'h000000, 16'h0000);
        send_item(OP_BACK, 8'h00, 24'h000000, 16'h0000);
        send_item(OP_CLEAR, 8'hff, 24'hffffff, 16'hffff);
        maybe_idle(1'b0);
        send_item(OP_BACK, 8'h00, 24'h000000, 16'h0000);
        send_item(OP_FORWARD, 8'h00, 24'h000000, 16'h0000);
        send_item(OP_CLEAR, 8'h00, 24'h000000, 16'h0000);
        send_item(OP_PUSH, 8'h01, 24'h000001, 16'h0001);
        // a single entry has nowhere to move
        send_item(OP_BACK, 8'h00, 24'h000000, 16'h0000);
        send_item(OP_FORWARD, 8'h00, 24'h000000, 16'h0000);
        maybe_idle(1'b0);

        // the first segment is long enough to fill and wrap the ring
        sent = 0;
        seg  = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mode = (seg == 0) ? 0 : $urandom_range(0, 3);
            if (seg == 0)
                len = 170;
            else if (mode == 0)
                len = $urandom_range(40, 140);
            else
                len = $urandom_range(15, 60);
            for (int i = 0; i < len && sent < RANDOM_ITEMS; i++)
            begin
                send_random(mode);
                sent++;
                maybe_idle(sent >= 250 && sent < 370);
            end
            seg++;
        end

        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/njh_pkg.sv
rtl/navigation_jump_history_top.sv
rtl/njh_checker.sv
verif/navigation_jump_history_checker.sv
verif/testbench.sv
